[sv/chd_pkg.sv]
// shared types, constants and the timer step function for the
// capillary heater defrost sequencer; no dependencies
package chd_pkg;

  localparam int TIMER_BITS = 12;
  localparam int LIMIT_W    = 12;
  localparam int CMP_W      = (TIMER_BITS > LIMIT_W) ? TIMER_BITS : LIMIT_W;
  localparam int THR_W      = 11;
  localparam int TEMP_W     = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [TIMER_BITS-1:0] CNT_MAX = {TIMER_BITS{1'b1}};

  typedef enum logic [1:0] {
    KIND_EVAL   = 2'd0,
    KIND_SECOND = 2'd1,
    KIND_MINUTE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLD_THR   = 3'd0,
    REG_INTERVAL   = 3'd1,
    REG_WAIT       = 3'd2,
    REG_GUARD      = 3'd3,
    REG_AUTO_RUN   = 3'd4,
    REG_FORCED_RUN = 3'd5,
    REG_STOP_DELAY = 3'd6,
    REG_UNUSED     = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [THR_W-1:0] cold_start_threshold;
    logic [LIMIT_W-1:0]      interval_minutes;
    logic [LIMIT_W-1:0]      wait_minutes;
    logic [LIMIT_W-1:0]      guard_seconds;
    logic [LIMIT_W-1:0]      auto_run_seconds;
    logic [LIMIT_W-1:0]      forced_run_seconds;
    logic [LIMIT_W-1:0]      stop_delay_seconds;
  } cfg_t;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [TEMP_W-1:0] cabinet_temp;
    logic                     compressor_running;
    logic                     force_request;
    logic                     compressor_stopped_pulse;
  } item_t;

  typedef struct packed {
    logic heater_on;
    logic heating_requested;
    logic compressor_stop_request;
    logic interval_active;
  } result_t;

  typedef struct packed {
    logic                  flag;
    logic [TIMER_BITS-1:0] count;
    logic                  expired;
  } timer_t;

  // one tick of a running timer: saturating increment, expire at limit
  function automatic timer_t timer_step(input logic flag,
                                        input logic [TIMER_BITS-1:0] count,
                                        input logic [LIMIT_W-1:0] limit);
    timer_t t;
    logic [TIMER_BITS-1:0] inc;
    t.flag    = flag;
    t.count   = count;
    t.expired = 1'b0;
    if (flag) begin
      inc = (count < CNT_MAX) ? count + TIMER_BITS'(1) : count;
      if (CMP_W'(inc) >= CMP_W'(limit)) begin
        t.flag    = 1'b0;
        t.count   = '0;
        t.expired = 1'b1;
      end else begin
        t.count = inc;
      end
    end
    return t;
  endfunction

endpackage

[sv/capillary_heater_defrost_sequencer.sv]
// capillary heater defrost sequencer: a request goes from the input register
// through the state update into the result register; one request per cycle
// while out_ready holds; every request yields exactly one result
// ready falls only when both the input and the result register are full and
// out_ready is low; the state update is one pass of flag and counter logic
// synchronous active-low reset clears state, timers and both valid bits and
// loads the configuration registers with their default values
module capillary_heater_defrost_sequencer
  import chd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  // configuration write channel, always ready
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  // request channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_kind,
  input  logic signed [TEMP_W-1:0] in_cabinet_temp,
  input  logic                     in_compressor_running,
  input  logic                     in_force_request,
  input  logic                     in_compressor_stopped_pulse,
  // result channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_heater_on,
  output logic                     out_heating_requested,
  output logic                     out_compressor_stop_request,
  output logic                     out_interval_active
);

  cfg_t    cfg;
  item_t   item_r;
  logic    item_valid_r;
  result_t res_nxt;
  result_t res_r;
  logic    out_valid_r;
  logic    advance;

  // configuration registers
  assign cfg_ready = 1'b1;

  chd_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // the held request moves on when the result register is empty or drains
  assign advance  = item_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !item_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.kind                     <= in_kind;
      item_r.cabinet_temp             <= in_cabinet_temp;
      item_r.compressor_running       <= in_compressor_running;
      item_r.force_request            <= in_force_request;
      item_r.compressor_stopped_pulse <= in_compressor_stopped_pulse;
    end
  end

  // sequencer state, updated once per request as it leaves the input register
  chd_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (item_r),
    .cfg    (cfg),
    .result (res_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid                   = out_valid_r;
  assign out_heater_on               = res_r.heater_on;
  assign out_heating_requested       = res_r.heating_requested;
  assign out_compressor_stop_request = res_r.compressor_stop_request;
  assign out_interval_active         = res_r.interval_active;

endmodule

[sv/chd_cfg.sv]
// configuration register file of the defrost sequencer
// depends on chd_pkg
module chd_cfg
  import chd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cold_start_threshold <= '0;
      cfg_r.interval_minutes     <= LIMIT_W'(960);
      cfg_r.wait_minutes         <= LIMIT_W'(60);
      cfg_r.guard_seconds        <= LIMIT_W'(180);
      cfg_r.auto_run_seconds     <= LIMIT_W'(360);
      cfg_r.forced_run_seconds   <= LIMIT_W'(600);
      cfg_r.stop_delay_seconds   <= LIMIT_W'(180);
    end else if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_COLD_THR:   cfg_r.cold_start_threshold <= wr_data[THR_W-1:0];
        REG_INTERVAL:   cfg_r.interval_minutes     <= wr_data[LIMIT_W-1:0];
        REG_WAIT:       cfg_r.wait_minutes         <= wr_data[LIMIT_W-1:0];
        REG_GUARD:      cfg_r.guard_seconds        <= wr_data[LIMIT_W-1:0];
        REG_AUTO_RUN:   cfg_r.auto_run_seconds     <= wr_data[LIMIT_W-1:0];
        REG_FORCED_RUN: cfg_r.forced_run_seconds   <= wr_data[LIMIT_W-1:0];
        REG_STOP_DELAY: cfg_r.stop_delay_seconds   <= wr_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[sv/chd_core.sv]
// sequencer state and its one-item update logic
// depends on chd_pkg
module chd_core
  import chd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  logic first_pass_r, request_r, comp_hold_r, heater_r, forced_r;
  logic interval_r, wait_r, guard_r, run_r, stopdelay_r;
  logic [TIMER_BITS-1:0] interval_cnt_r, wait_cnt_r, guard_cnt_r, run_cnt_r, stopdelay_cnt_r;

  logic first_pass_nxt, request_nxt, comp_hold_nxt, heater_nxt, forced_nxt;
  logic interval_nxt, wait_nxt, guard_nxt, run_nxt, stopdelay_nxt;
  logic [TIMER_BITS-1:0] interval_cnt_nxt, wait_cnt_nxt, guard_cnt_nxt;
  logic [TIMER_BITS-1:0] run_cnt_nxt, stopdelay_cnt_nxt;

  logic signed [TEMP_W-1:0] thr_ext;
  timer_t t_guard, t_run, t_stop, t_int, t_wait;

  assign thr_ext = {cfg.cold_start_threshold[THR_W-1], cfg.cold_start_threshold};

  always_comb begin
    first_pass_nxt    = first_pass_r;
    request_nxt       = request_r;
    comp_hold_nxt     = comp_hold_r;
    heater_nxt        = heater_r;
    forced_nxt        = forced_r;
    interval_nxt      = interval_r;
    wait_nxt          = wait_r;
    guard_nxt         = guard_r;
    run_nxt           = run_r;
    stopdelay_nxt     = stopdelay_r;
    interval_cnt_nxt  = interval_cnt_r;
    wait_cnt_nxt      = wait_cnt_r;
    guard_cnt_nxt     = guard_cnt_r;
    run_cnt_nxt       = run_cnt_r;
    stopdelay_cnt_nxt = stopdelay_cnt_r;

    // restart guard pulse goes first, whatever the kind
    if (item.compressor_stopped_pulse) begin
      guard_nxt     = 1'b1;
      guard_cnt_nxt = '0;
    end

    t_guard = timer_step(guard_nxt, guard_cnt_nxt, cfg.guard_seconds);
    t_run   = timer_step(run_r, run_cnt_r,
                         forced_r ? cfg.forced_run_seconds : cfg.auto_run_seconds);
    t_stop  = timer_step(stopdelay_r, stopdelay_cnt_r, cfg.stop_delay_seconds);
    t_int   = timer_step(interval_r, interval_cnt_r, cfg.interval_minutes);
    t_wait  = timer_step(wait_r, wait_cnt_r, cfg.wait_minutes);

    case (kind_t'(item.kind))
      KIND_EVAL: begin
        if (item.force_request) begin
          forced_nxt       = 1'b1;
          interval_nxt     = 1'b0;
          interval_cnt_nxt = '0;
          request_nxt      = 1'b1;
          comp_hold_nxt    = 1'b1;
        end
        if (!request_nxt) begin
          if (!interval_nxt) begin
            if (first_pass_r) begin
              first_pass_nxt = 1'b0;
              if (item.cabinet_temp <= thr_ext) begin
                request_nxt   = 1'b1;
                comp_hold_nxt = 1'b1;
              end else begin
                interval_nxt     = 1'b1;
                interval_cnt_nxt = '0;
              end
            end else begin
              request_nxt  = 1'b1;
              wait_nxt     = 1'b1;
              wait_cnt_nxt = '0;
            end
          end
        end else if (!item.compressor_running) begin
          wait_nxt      = 1'b0;
          wait_cnt_nxt  = '0;
          comp_hold_nxt = 1'b1;
          if (!heater_r) begin
            if (!guard_nxt) begin
              heater_nxt  = 1'b1;
              run_nxt     = 1'b1;
              run_cnt_nxt = '0;
            end
          end else if (!run_r) begin
            // heater done: start stop delay and the next long interval
            heater_nxt        = 1'b0;
            stopdelay_nxt     = 1'b1;
            stopdelay_cnt_nxt = '0;
            forced_nxt        = 1'b0;
            request_nxt       = 1'b0;
            interval_nxt      = 1'b1;
            interval_cnt_nxt  = '0;
          end
        end
      end
      KIND_SECOND: begin
        guard_nxt         = t_guard.flag;
        guard_cnt_nxt     = t_guard.count;
        run_nxt           = t_run.flag;
        run_cnt_nxt       = t_run.count;
        stopdelay_nxt     = t_stop.flag;
        stopdelay_cnt_nxt = t_stop.count;
        if (t_stop.expired) begin
          comp_hold_nxt = 1'b0;
        end
      end
      KIND_MINUTE: begin
        interval_nxt     = t_int.flag;
        interval_cnt_nxt = t_int.count;
        wait_nxt         = t_wait.flag;
        wait_cnt_nxt     = t_wait.count;
        if (t_wait.expired) begin
          comp_hold_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_pass_r    <= 1'b1;
      request_r       <= 1'b0;
      comp_hold_r     <= 1'b0;
      heater_r        <= 1'b0;
      forced_r        <= 1'b0;
      interval_r      <= 1'b0;
      wait_r          <= 1'b0;
      guard_r         <= 1'b0;
      run_r           <= 1'b0;
      stopdelay_r     <= 1'b0;
      interval_cnt_r  <= '0;
      wait_cnt_r      <= '0;
      guard_cnt_r     <= '0;
      run_cnt_r       <= '0;
      stopdelay_cnt_r <= '0;
    end else if (step) begin
      first_pass_r    <= first_pass_nxt;
      request_r       <= request_nxt;
      comp_hold_r     <= comp_hold_nxt;
      heater_r        <= heater_nxt;
      forced_r        <= forced_nxt;
      interval_r      <= interval_nxt;
      wait_r          <= wait_nxt;
      guard_r         <= guard_nxt;
      run_r           <= run_nxt;
      stopdelay_r     <= stopdelay_nxt;
      interval_cnt_r  <= interval_cnt_nxt;
      wait_cnt_r      <= wait_cnt_nxt;
      guard_cnt_r     <= guard_cnt_nxt;
      run_cnt_r       <= run_cnt_nxt;
      stopdelay_cnt_r <= stopdelay_cnt_nxt;
    end
  end

  assign result.heater_on               = heater_nxt;
  assign result.heating_requested       = request_nxt;
  assign result.compressor_stop_request = comp_hold_nxt;
  assign result.interval_active         = interval_nxt;

  a_run_needs_heater: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> heater_r) else $error("run timer active with heater off");

  a_heater_needs_request: assert property (@(posedge clk) disable iff (!rst_n)
    heater_r |-> request_r) else $error("heater on without a heating request");

  a_idle_guard_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !guard_r |-> (guard_cnt_r == '0)) else $error("idle guard timer holds a count");

  a_idle_wait_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !wait_r |-> (wait_cnt_r == '0)) else $error("idle wait timer holds a count");

endmodule

[bench/tb_top.sv]
// self-checking bench for capillary_heater_defrost_sequencer: directed and random
// requests, a scoreboard class that predicts every result, random idling on both sides
// depends on chd_pkg (sv/chd_pkg.sv) and the sequencer rtl
module tb_top;
  import chd_pkg::*;

  // timer slots of the predictor
  typedef enum int {
    TMR_INTERVAL = 0,
    TMR_WAIT     = 1,
    TMR_GUARD    = 2,
    TMR_RUN      = 3,
    TMR_STOP     = 4
  } tmr_t;

  // predicts heater drive outputs and checks them in order
  class defrost_checker_t;
    // register copies
    int          cold_thr;
    int unsigned interval_lim, wait_lim, guard_lim;
    int unsigned auto_lim, forced_lim, stop_lim;
    // sequencer state
    bit          first_pass, requested, hold, heater, forced;
    bit          tmr_on[5];
    int unsigned tmr_cnt[5];
    result_t     drive_queue[$];
    int unsigned failures;

    function new();
      cold_thr     = 0;
      interval_lim = 960;
      wait_lim     = 60;
      guard_lim    = 180;
      auto_lim     = 360;
      forced_lim   = 600;
      stop_lim     = 180;
      first_pass   = 1'b1;
      requested    = 1'b0;
      hold         = 1'b0;
      heater       = 1'b0;
      forced       = 1'b0;
      failures     = 0;
      foreach (tmr_on[i]) begin
        tmr_on[i]  = 1'b0;
        tmr_cnt[i] = 0;
      end
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_COLD_THR:   cold_thr = int'($signed(data[THR_W-1:0]));
        REG_INTERVAL:   interval_lim = int'(data);
        REG_WAIT:       wait_lim = int'(data);
        REG_GUARD:      guard_lim = int'(data);
        REG_AUTO_RUN:   auto_lim = int'(data);
        REG_FORCED_RUN: forced_lim = int'(data);
        REG_STOP_DELAY: stop_lim = int'(data);
        default: ;
      endcase
    endfunction

    function void restart(tmr_t id);
      tmr_on[id]  = 1'b1;
      tmr_cnt[id] = 0;
    endfunction

    // saturating count, returns 1 on expiry
    function bit tick(tmr_t id, int unsigned limit);
      if (!tmr_on[id]) return 1'b0;
      if (tmr_cnt[id] < (1 << TIMER_BITS) - 1) tmr_cnt[id]++;
      if (tmr_cnt[id] >= limit) begin
        tmr_on[id]  = 1'b0;
        tmr_cnt[id] = 0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void evaluate(item_t it);
      if (it.force_request) begin
        forced = 1'b1;
        tmr_on[TMR_INTERVAL]  = 1'b0;
        tmr_cnt[TMR_INTERVAL] = 0;
        requested = 1'b1;
        hold      = 1'b1;
      end
      if (!requested) begin
        if (!tmr_on[TMR_INTERVAL]) begin
          if (first_pass) begin
            first_pass = 1'b0;
            if ($signed(it.cabinet_temp) <= cold_thr) begin
              requested = 1'b1;
              hold      = 1'b1;
            end else begin
              restart(TMR_INTERVAL);
            end
          end else begin
            requested = 1'b1;
            restart(TMR_WAIT);
          end
        end
      end else if (!it.compressor_running) begin
        tmr_on[TMR_WAIT]  = 1'b0;
        tmr_cnt[TMR_WAIT] = 0;
        hold = 1'b1;
        if (!heater) begin
          if (!tmr_on[TMR_GUARD]) begin
            heater = 1'b1;
            restart(TMR_RUN);
          end
        end else if (!tmr_on[TMR_RUN]) begin
          heater    = 1'b0;
          restart(TMR_STOP);
          forced    = 1'b0;
          requested = 1'b0;
          restart(TMR_INTERVAL);
        end
      end
    endfunction

    // accepted request: step the state and queue the expected drive
    function void note_request(item_t it);
      result_t r;
      if (it.compressor_stopped_pulse) restart(TMR_GUARD);
      case (kind_t'(it.kind))
        KIND_EVAL: evaluate(it);
        KIND_SECOND: begin
          void'(tick(TMR_GUARD, guard_lim));
          void'(tick(TMR_RUN, forced ? forced_lim : auto_lim));
          if (tick(TMR_STOP, stop_lim)) hold = 1'b0;
        end
        KIND_MINUTE: begin
          void'(tick(TMR_INTERVAL, interval_lim));
          if (tick(TMR_WAIT, wait_lim)) hold = 1'b1;
        end
        default: ;
      endcase
      r.heater_on               = heater;
      r.heating_requested       = requested;
      r.compressor_stop_request = hold;
      r.interval_active         = tmr_on[TMR_INTERVAL];
      drive_queue.push_back(r);
    endfunction

    function void check_drive(result_t got);
      result_t want;
      if (drive_queue.size() == 0) begin
        failures++;
        if (failures <= 10) $display("result with no request outstanding: %b", got);
        return;
      end
      want = drive_queue.pop_front();
      if (got.heater_on !== want.heater_on ||
          got.heating_requested !== want.heating_requested ||
          got.compressor_stop_request !== want.compressor_stop_request ||
          got.interval_active !== want.interval_active) begin
        failures++;
        if (failures <= 10)
          $display("mismatch heater/req/hold/interval: expected %b%b%b%b got %b%b%b%b",
                   want.heater_on, want.heating_requested, want.compressor_stop_request,
                   want.interval_active, got.heater_on, got.heating_requested,
                   got.compressor_stop_request, got.interval_active);
      end
    endfunction

    function int pending();
      return drive_queue.size();
    endfunction
  endclass

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  always #10 clk = ~clk;

  // block inputs, all known from time zero
  logic                     cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data  = '0;
  logic                     in_valid  = 1'b0;
  logic [1:0]               in_kind   = '0;
  logic signed [TEMP_W-1:0] in_cabinet_temp = '0;
  logic                     in_compressor_running = 1'b0;
  logic                     in_force_request = 1'b0;
  logic                     in_compressor_stopped_pulse = 1'b0;
  logic                     out_ready = 1'b0;

  // block outputs
  logic cfg_ready, in_ready, out_valid;
  logic out_heater_on, out_heating_requested, out_compressor_stop_request;
  logic out_interval_active;

  capillary_heater_defrost_sequencer uut (
    .clk                         (clk),
    .rst_n                       (rst_n),
    .cfg_valid                   (cfg_valid),
    .cfg_ready                   (cfg_ready),
    .cfg_index                   (cfg_index),
    .cfg_data                    (cfg_data),
    .in_valid                    (in_valid),
    .in_ready                    (in_ready),
    .in_kind                     (in_kind),
    .in_cabinet_temp             (in_cabinet_temp),
    .in_compressor_running       (in_compressor_running),
    .in_force_request            (in_force_request),
    .in_compressor_stopped_pulse (in_compressor_stopped_pulse),
    .out_valid                   (out_valid),
    .out_ready                   (out_ready),
    .out_heater_on               (out_heater_on),
    .out_heating_requested       (out_heating_requested),
    .out_compressor_stop_request (out_compressor_stop_request),
    .out_interval_active         (out_interval_active)
  );

  defrost_checker_t sb;

  // idling odds in percent, set per phase
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;

  // receiver: random stalls at the current odds
  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  // monitor: values seen here are the ones before the edge
  item_t   seen_req;
  result_t seen_drive;
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_reg_t'(cfg_index), cfg_data);
      if (in_valid && in_ready) begin
        seen_req.kind                     = in_kind;
        seen_req.cabinet_temp             = in_cabinet_temp;
        seen_req.compressor_running       = in_compressor_running;
        seen_req.force_request            = in_force_request;
        seen_req.compressor_stopped_pulse = in_compressor_stopped_pulse;
        sb.note_request(seen_req);
      end
      if (out_valid && out_ready) begin
        seen_drive.heater_on               = out_heater_on;
        seen_drive.heating_requested       = out_heating_requested;
        seen_drive.compressor_stop_request = out_compressor_stop_request;
        seen_drive.interval_active         = out_interval_active;
        sb.check_drive(seen_drive);
      end
    end
  end

  // one register write; cfg_valid stays high for back-to-back writes
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // full register set, only called with the block idle
  task automatic apply_setting(int thr, int unsigned ivl, int unsigned wt,
                               int unsigned grd, int unsigned arun,
                               int unsigned frun, int unsigned sdly);
    write_reg(REG_COLD_THR, CFG_DATA_W'(thr));
    write_reg(REG_INTERVAL, CFG_DATA_W'(ivl));
    write_reg(REG_WAIT, CFG_DATA_W'(wt));
    write_reg(REG_GUARD, CFG_DATA_W'(grd));
    write_reg(REG_AUTO_RUN, CFG_DATA_W'(arun));
    write_reg(REG_FORCED_RUN, CFG_DATA_W'(frun));
    write_reg(REG_STOP_DELAY, CFG_DATA_W'(sdly));
    // unmapped index, must change nothing
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // sender: random gap, then hold the request until accepted
  task automatic send_request(item_t it);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid                    <= 1'b1;
    in_kind                     <= it.kind;
    in_cabinet_temp             <= it.cabinet_temp;
    in_compressor_running       <= it.compressor_running;
    in_force_request            <= it.force_request;
    in_compressor_stopped_pulse <= it.compressor_stopped_pulse;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic item_t make_request(kind_t k, int temp, int run, int frc, int pls);
    item_t it;
    it.kind                     = k;
    it.cabinet_temp             = TEMP_W'(temp);
    it.compressor_running       = run[0];
    it.force_request            = frc[0];
    it.compressor_stopped_pulse = pls[0];
    return it;
  endfunction

  // mostly loop passes and second ticks, some minute ticks, a few unused kinds
  function automatic item_t random_request();
    int    r;
    kind_t k;
    r = $urandom_range(99);
    if (r < 40)      k = KIND_EVAL;
    else if (r < 75) k = KIND_SECOND;
    else if (r < 95) k = KIND_MINUTE;
    else             k = KIND_NONE;
    return make_request(k, int'($urandom_range(3500)) - 2000, int'($urandom_range(1)),
                        int'($urandom_range(99) < 4), int'($urandom_range(99) < 8));
  endfunction

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // short timers so the directed walk covers a whole cycle
    apply_setting(1000, 2, 1, 1, 2, 3, 1);

    // first pass while warm starts the interval
    send_request(make_request(KIND_EVAL, 1500, 1, 0, 0));
    send_request(make_request(KIND_MINUTE, 0, 1, 0, 0));
    send_request(make_request(KIND_EVAL, -2000, 1, 0, 0));
    send_request(make_request(KIND_MINUTE, 0, 1, 0, 0));
    // interval over: request and wait for compressor
    send_request(make_request(KIND_EVAL, -2000, 1, 0, 0));
    send_request(make_request(KIND_MINUTE, 0, 1, 0, 0));
    send_request(make_request(KIND_EVAL, 0, 1, 0, 0));
    // compressor off but restart guard running
    send_request(make_request(KIND_EVAL, 0, 0, 0, 1));
    send_request(make_request(KIND_SECOND, 0, 0, 0, 0));
    send_request(make_request(KIND_NONE, 0, 0, 0, 0));
    // automatic heater run
    send_request(make_request(KIND_EVAL, 0, 0, 0, 0));
    send_request(make_request(KIND_SECOND, 0, 0, 0, 0));
    send_request(make_request(KIND_SECOND, 0, 0, 0, 0));
    send_request(make_request(KIND_EVAL, 0, 0, 0, 0));
    send_request(make_request(KIND_SECOND, 0, 0, 0, 0));
    // forced cycle with its own run time
    send_request(make_request(KIND_EVAL, 0, 1, 1, 0));
    send_request(make_request(KIND_EVAL, 0, 0, 0, 0));
    repeat (3) send_request(make_request(KIND_SECOND, 0, 0, 0, 0));
    send_request(make_request(KIND_EVAL, 0, 0, 0, 0));
    // unused kind with every flag set
    send_request(make_request(KIND_NONE, 1500, 1, 1, 1));
    send_request(make_request(KIND_SECOND, 0, 1, 0, 0));
    drain_results();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 76; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 76; end
        default: begin gap_pct = 16; stall_pct = 16; end
      endcase
      case (ph)
        1: apply_setting(-1000, 1, 1, 1, 1, 1, 1);
        // zero limits expire on the next tick
        2: apply_setting(1000, 0, 0, 0, 0, 0, 0);
        4: apply_setting(1000, 4095, 4095, 4095, 4095, 4095, 4095);
        5: apply_setting(0, 960, 60, 180, 360, 600, 180);
        default:
          apply_setting(int'($urandom_range(2000)) - 1000, $urandom_range(1, 8),
                        $urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 8),
                        $urandom_range(1, 8), $urandom_range(1, 8));
      endcase
      for (int i = 0; i < 125; i++) begin
        // sender holds off until the block has answered everything
        if (ph == 2 && i == 60) drain_results();
        send_request(random_request());
      end
      drain_results();
    end

    // let any stray result show up
    repeat (8) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("[capillary_heater_defrost_sequencer] OK");
    end else begin
      $display("[capillary_heater_defrost_sequencer] ERROR");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #8000000;
    $display("[capillary_heater_defrost_sequencer] ERROR");
    $finish;
  end

endmodule

[filelist.f]
sv/chd_pkg.sv
sv/chd_cfg.sv
sv/chd_core.sv
sv/capillary_heater_defrost_sequencer.sv
bench/tb_top.sv
